>>> src/swp_pkg.sv
// Package for the stopwatch with pause timeouts: modes, commands, widths,
// divide-by-constant reciprocals and the shared config and beat structs.
// No dependencies.
package swp_pkg;

  localparam int TsW       = 64;
  localparam int CfgW      = 10;
  localparam int ThrW      = 30;
  localparam int SecW      = 10;
  localparam int MsW       = 10;
  localparam int ResW      = 20;
  localparam int SumW      = 31;
  localparam int QsW       = 12;
  localparam int UsPerSec  = 1000000;
  localparam int UsPerMs   = 1000;
  localparam int SecMax    = 999;
  localparam int CmdW      = 2;
  localparam int ModeW     = 3;
  localparam int InDataW   = ((TsW + 7) / 8) * 8;
  localparam int OutFieldW = ModeW + SecW + MsW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [63:0] SatUs    = 64'd1000000000;
  localparam logic [30:0] RecipSec = 31'(((64'd1 << 50) + 64'(UsPerSec) - 64'd1) / 64'(UsPerSec));
  localparam logic [31:0] RecipRes = 32'(((64'd1 << 51) + 64'(UsPerSec) - 64'd1) / 64'(UsPerSec));
  localparam logic [20:0] RecipMs  = 21'(((64'd1 << 30) + 64'(UsPerMs) - 64'd1) / 64'(UsPerMs));

  typedef enum logic [ModeW-1:0] {
    ModeInit  = 3'd0,
    ModeRun   = 3'd1,
    ModePause = 3'd2,
    ModeReset = 3'd3,
    ModeTo1   = 3'd4,
    ModeTo2   = 3'd5
  } mode_e;

  typedef enum logic [CmdW-1:0] {
    CmdTick  = 2'd0,
    CmdStart = 2'd1,
    CmdStop  = 2'd2,
    CmdReset = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    RegFirst  = 1'b0,
    RegSecond = 1'b1
  } reg_e;

  typedef struct packed {
    logic [ThrW-1:0] thr1;
    logic [ThrW-1:0] thr2;
  } cfg_t;

  typedef struct packed {
    mode_e          mode;
    logic [TsW-1:0] elapsed;
  } item_t;

  function automatic logic [ResW-1:0] chunk_res(int idx);
    logic [39:0] r;
    r = 40'd1;
    for (int k = 0; k < idx * 8; k++) begin
      r = (r * 40'd2) % 40'(UsPerSec);
    end
    return ResW'(r);
  endfunction

endpackage

>>> src/swp_cfg.sv
// APB register file: both timeout thresholds, kept in seconds for readback
// and in microseconds for the pause compare. Depends on swp_pkg.
module swp_cfg import swp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [CfgW-1:0] first_q, second_q;
  logic [ThrW-1:0] thr1_q, thr2_q;
  logic            wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= CfgW'(30);
      second_q <= CfgW'(60);
      thr1_q   <= ThrW'(30 * UsPerSec);
      thr2_q   <= ThrW'(60 * UsPerSec);
    end else if (wr) begin
      unique case (reg_e'(paddr[2]))
        RegFirst: begin
          first_q <= pwdata[CfgW-1:0];
          thr1_q  <= ThrW'(pwdata[CfgW-1:0]) * ThrW'(UsPerSec);
        end
        RegSecond: begin
          second_q <= pwdata[CfgW-1:0];
          thr2_q   <= ThrW'(pwdata[CfgW-1:0]) * ThrW'(UsPerSec);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      RegFirst:  prdata = 32'(first_q);
      RegSecond: prdata = 32'(second_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.thr1 = thr1_q;
  assign cfg_o.thr2 = thr2_q;

endmodule

>>> src/swp_core.sv
// Stopwatch state: mode, start, pause and elapsed registers updated once per
// accepted command beat. Depends on swp_pkg.
module swp_core import swp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [CmdW-1:0] cmd_i,
  input  logic [TsW-1:0] now_i,
  input  cfg_t           cfg_i,
  output item_t          item_o
);

  mode_e          mode_q, mode_d;
  logic [TsW-1:0] start_q, start_d;
  logic [TsW-1:0] pause_q, pause_d;
  logic [TsW-1:0] elap_q, elap_d;
  logic [TsW-1:0] diff_p;

  assign diff_p = now_i - pause_q;

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    pause_d = pause_q;
    elap_d  = elap_q;
    unique case (cmd_e'(cmd_i))
      CmdStart: begin
        if (mode_q == ModePause && elap_q != '0) begin
          start_d = start_q + diff_p;
        end
        mode_d = ModeRun;
      end
      CmdStop: begin
        if (mode_q != ModeReset && mode_q != ModeInit) begin
          pause_d = now_i;
          mode_d  = ModePause;
        end
      end
      CmdReset: mode_d = ModeReset;
      CmdTick: begin
        unique case (mode_q)
          ModeRun: elap_d = now_i - start_q;
          ModePause: begin
            if (diff_p >= TsW'(cfg_i.thr1)) begin
              mode_d = ModeTo1;
            end
          end
          ModeTo1: begin
            if (diff_p >= TsW'(cfg_i.thr2)) begin
              mode_d = ModeTo2;
            end
          end
          ModeTo2: begin
          end
          ModeReset: begin
            start_d = now_i;
            pause_d = '0;
            elap_d  = '0;
          end
          default: start_d = now_i;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeInit;
      start_q <= '0;
      pause_q <= '0;
      elap_q  <= '0;
    end else if (acc_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pause_q <= pause_d;
      elap_q  <= elap_d;
    end
  end

  assign item_o.mode    = mode_d;
  assign item_o.elapsed = elap_d;

endmodule

>>> src/swp_fmt.sv
// Six-stage formatting pipeline: elapsed microseconds to saturated seconds
// and milliseconds by residues and reciprocal multiplies. Depends on swp_pkg.
module swp_fmt import swp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ModeW-1:0]  mode_o,
  output logic [SecW-1:0]   secs_o,
  output logic [MsW-1:0]    millis_o
);

  localparam int NStg   = 6;
  localparam int NChunk = (TsW + 7) / 8;
  localparam int PadW   = NChunk * 8;
  localparam int ProdW  = 8 + ResW;

  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;

  mode_e           mode_q [NStg];
  logic [TsW-1:0]  el0_q;
  logic [PadW-1:0] el_pad;
  logic [ProdW-1:0] prod_d [NChunk];
  logic [ProdW-1:0] prod_q [NChunk];
  logic            sat1_q;
  logic [29:0]     low1_q;
  logic [SumW-1:0] sum_d, sum2_q, sum3_q;
  logic [60:0]     sec_prod;
  logic [SecW-1:0] secs_d;
  logic [SecW-1:0] secs_q [2:NStg-1];
  logic [62:0]     qs_prod;
  logic [QsW-1:0]  qs3_q;
  logic [SumW-1:0] res_full;
  logic [ResW-1:0] res4_q;
  logic [40:0]     ms_prod;
  logic [MsW-1:0]  ms5_q;

  assign rdy[NStg] = out_ready_i;
  for (genvar k = 0; k < NStg; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign el_pad = PadW'(el0_q);
  for (genvar g = 0; g < NChunk; g++) begin : g_chunk
    localparam logic [ResW-1:0] Res = chunk_res(g);
    assign prod_d[g] = ProdW'(el_pad[g*8 +: 8]) * ProdW'(Res);
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NChunk; i++) begin
      sum_d = sum_d + SumW'(prod_q[i]);
    end
  end

  assign sec_prod = 61'(low1_q) * 61'(RecipSec);
  assign secs_d   = sat1_q ? SecW'(SecMax) : sec_prod[59:50];
  assign qs_prod  = 63'(sum2_q) * 63'(RecipRes);
  assign res_full = sum3_q - SumW'(qs3_q * SumW'(UsPerSec));
  assign ms_prod  = 41'(res4_q) * 41'(RecipMs);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mode_q[0] <= item_i.mode;
      el0_q     <= item_i.elapsed;
    end
    if (rdy[1]) begin
      mode_q[1] <= mode_q[0];
      prod_q    <= prod_d;
      sat1_q    <= 64'(el0_q) >= SatUs;
      low1_q    <= el0_q[29:0];
    end
    if (rdy[2]) begin
      mode_q[2] <= mode_q[1];
      sum2_q    <= sum_d;
      secs_q[2] <= secs_d;
    end
    if (rdy[3]) begin
      mode_q[3] <= mode_q[2];
      sum3_q    <= sum2_q;
      qs3_q     <= qs_prod[62:51];
      secs_q[3] <= secs_q[2];
    end
    if (rdy[4]) begin
      mode_q[4] <= mode_q[3];
      res4_q    <= res_full[ResW-1:0];
      secs_q[4] <= secs_q[3];
    end
    if (rdy[5]) begin
      mode_q[5] <= mode_q[4];
      ms5_q     <= ms_prod[39:30];
      secs_q[5] <= secs_q[4];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NStg-1];
  assign mode_o      = mode_q[NStg-1];
  assign secs_o      = secs_q[NStg-1];
  assign millis_o    = ms5_q;

  a_secs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> secs_o <= SecW'(SecMax))
    else $error("seconds out of range");

  a_millis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> millis_o <= MsW'(SecMax))
    else $error("milliseconds out of range");

  a_sat_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && rdy[2] && sat1_q) |=> secs_q[2] == SecW'(SecMax))
    else $error("saturated elapsed time not clamped");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && rdy[4]) |=> res4_q < ResW'(UsPerSec))
    else $error("microsecond residue not reduced");

endmodule

>>> src/stopwatch_with_pause_timeouts.sv
// Top level of the stopwatch with pause timeouts: stream channels, APB
// register port, state core and formatting pipeline.
// Depends on swp_pkg, swp_cfg, swp_core and swp_fmt.
//
// Each slave beat carries a command in s_axis_tuser (tick, start, stop,
// reset) and the current microsecond timestamp in s_axis_tdata. Every beat
// yields exactly one master beat with the mode after the command and the
// elapsed time as whole seconds (saturating at 999) and milliseconds.
// Throughput is one beat per cycle unless the master side stalls: then results
// hold in the pipeline, s_axis_tready drops only once all six stages are full,
// and bubbles are squeezed out. A result leaves through the six-register
// formatting pipeline (input, residue products, residue sum, seconds quotient,
// remainder, milliseconds). The stopwatch state itself is updated in the cycle
// the beat is accepted. Reset clears the pipeline, puts the stopwatch in init
// mode with zero times and loads the timeout thresholds with 30 and 60
// seconds. The thresholds are written over APB at offsets 0x0 and 0x4 by the
// user, only while the block is idle; the block does not enforce this.
module stopwatch_with_pause_timeouts import swp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // now_us
  input  logic [CmdW-1:0]     s_axis_tuser,   // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // mode, elapsed_seconds, elapsed_millis
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t             cfg;
  item_t            item;
  logic             acc;
  logic [ModeW-1:0] mode;
  logic [SecW-1:0]  secs;
  logic [MsW-1:0]   millis;

  assign acc = s_axis_tvalid && s_axis_tready;

  swp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .cmd_i  (s_axis_tuser),
    .now_i  (s_axis_tdata[TsW-1:0]),
    .cfg_i  (cfg),
    .item_o (item)
  );

  swp_fmt u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mode_o      (mode),
    .secs_o      (secs),
    .millis_o    (millis)
  );

  assign m_axis_tdata = OutDataW'({millis, secs, mode});

endmodule
